// ===== src/best_fit_partition_allocator_core_assert.svh =====
// Assertion macros shared by the best-fit partition allocator RTL.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clk and quiet during rst.
`define BFPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfpa assertion failed");

// Next-cycle implication, checked on clk and quiet during rst.
`define BFPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfpa assertion failed");

`else

`define BFPA_ASSERT_NOW(label, ante, cons)
`define BFPA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/bfpa_pkg.sv =====
// Package with the constants and codes of the best-fit partition allocator.
`timescale 1ns / 1ps

package bfpa_pkg;

  // Storage geometry.
  localparam int NUM_PARTS = 8;
  localparam int SIZE_BITS = 16;
  localparam int PART_BITS = $clog2(NUM_PARTS);
  localparam int CNT_BITS  = $clog2(NUM_PARTS + 1);

  // Fixed widths of the interface fields.
  localparam int SLOT_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int CFG_W    = 4;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  // Register indexes (word address bits of paddr).
  localparam logic REG_PARTS_IN_USE = 1'b0;

  // Reset value of the partition count.
  localparam logic [CFG_W-1:0] PARTS_IN_USE_RST = CFG_W'(NUM_PARTS);

endpackage

// ===== src/best_fit_partition_allocator_core.sv =====
// Top level of the best-fit partition allocator with its free-space memory.
`timescale 1ns / 1ps

// The block keeps the free space of each partition in a small synchronous
// memory with a registered read. A load transaction writes one entry. A
// request transaction starts a scan: one entry is read per cycle and fed
// into a single compare unit that keeps the best fit found so far (smallest
// free space that still covers the request, lowest index on a tie). After
// the scan the chosen entry is written back with the request subtracted and
// the result transaction is placed in the output register. A request scans
// the first parts_in_use entries (parts_in_use saturated at the partition
// count) through the one read port of the memory; a request with
// parts_in_use of zero skips the scan and is refused. The input is stalled
// while a request is in progress, and it is also stalled while the finished
// result waits in the output register and another request would have to be
// written back. Loads and configuration writes are taken while a result
// waits downstream. Entries that were never loaded read as zero through
// per-entry valid bits, so no clearing pass is needed after reset. Register
// parts_in_use lies at byte address 0 of the APB port.

`include "best_fit_partition_allocator_core_assert.svh"

module best_fit_partition_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  // Input item channel.
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          kind,
  input  logic [bfpa_pkg::SLOT_W-1:0]   part_slot,
  input  logic [bfpa_pkg::AMOUNT_W-1:0] amount,
  // Result channel.
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          granted,
  output logic [bfpa_pkg::SLOT_W-1:0]   chosen_part,
  output logic [bfpa_pkg::AMOUNT_W-1:0] space_left,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfpa_pkg::DATA_W-1:0]   pwdata,
  output logic [bfpa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  import bfpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Control state.
  state_t               state;
  logic [CFG_W-1:0]     parts_in_use;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  issue_idx;
  logic                 rd_pend;
  logic [PART_BITS-1:0] rd_idx;
  logic                 found;
  logic [NUM_PARTS-1:0] part_ok;

  // Payload held for the request in progress.
  logic [SIZE_BITS-1:0] amount_q;
  logic [SIZE_BITS-1:0] best_val;
  logic [PART_BITS-1:0] best_idx;

  // Free-space memory and its read port.
  logic [SIZE_BITS-1:0] mem [NUM_PARTS];
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_ok;
  logic                 rd_en;
  logic [PART_BITS-1:0] rd_addr;

  // Write port.
  logic                 mem_we;
  logic [PART_BITS-1:0] mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  // Datapath.
  logic                 item_fire;
  logic                 out_free;
  logic                 cfg_write;
  logic [CNT_BITS-1:0]  cnt_sat;
  logic [SIZE_BITS-1:0] cur_val;
  logic                 better;
  logic                 scan_last;
  logic [SIZE_BITS-1:0] remain;
  logic                 load_ok;

  assign pready     = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_fire  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign cfg_write  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PARTS_IN_USE) begin
      prdata[CFG_W-1:0] = parts_in_use;
    end
  end

  // The partition count saturates at the number of partitions.
  always_comb begin
    if (int'(parts_in_use) > NUM_PARTS) begin
      cnt_sat = CNT_BITS'(NUM_PARTS);
    end else begin
      cnt_sat = CNT_BITS'(parts_in_use);
    end
  end

  assign rd_en   = (state == S_SCAN) && (issue_idx < cnt);
  assign rd_addr = issue_idx[PART_BITS-1:0];

  // An entry that was never written reads as empty.
  assign cur_val   = rd_ok ? rd_data : '0;
  assign better    = (cur_val >= amount_q) && (!found || (cur_val < best_val));
  assign scan_last = rd_pend && ({1'b0, rd_idx} == CNT_BITS'(cnt - 1'b1));
  assign remain    = best_val - amount_q;
  assign load_ok   = int'(part_slot) < NUM_PARTS;

  // Loads write in the idle state; a granted request writes back in S_DONE.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = remain;
    if (state == S_IDLE) begin
      mem_we    = item_fire && (kind == KIND_LOAD) && load_ok;
      mem_waddr = PART_BITS'(part_slot);
      mem_wdata = SIZE_BITS'(amount);
    end else if (state == S_DONE) begin
      mem_we = out_free && found;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_ok   <= part_ok[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      parts_in_use <= PARTS_IN_USE_RST;
      part_ok      <= '0;
      cnt          <= '0;
      issue_idx    <= '0;
      rd_pend      <= 1'b0;
      rd_idx       <= '0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == REG_PARTS_IN_USE)) begin
        parts_in_use <= pwdata[CFG_W-1:0];
      end
      if (mem_we) begin
        part_ok[mem_waddr] <= 1'b1;
      end
      // A finished request loads the output register; otherwise a taken
      // result empties it.
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_fire && (kind == KIND_ALLOC)) begin
            amount_q  <= SIZE_BITS'(amount);
            cnt       <= cnt_sat;
            issue_idx <= '0;
            rd_pend   <= 1'b0;
            found     <= 1'b0;
            best_idx  <= '0;
            best_val  <= '0;
            // With no partition searched the request is refused at once.
            state     <= (cnt_sat == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= rd_en;
          rd_idx  <= rd_addr;
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (rd_pend && better) begin
            found    <= 1'b1;
            best_val <= cur_val;
            best_idx <= rd_idx;
          end
          if (scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            granted     <= found;
            chosen_part <= found ? SLOT_W'(best_idx) : '0;
            space_left  <= found ? AMOUNT_W'(remain) : '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A refused request reports neither a partition nor any space.
  `BFPA_ASSERT_NOW(a_refused_zero, result_valid && !granted, {chosen_part, space_left} == '0)
  // An accepted request keeps the input stalled in the following cycle.
  `BFPA_ASSERT_NEXT(a_req_blocks, item_fire && (kind == KIND_ALLOC), item_stall)
  // The memory is never written while a scan is reading it.
  `BFPA_ASSERT_NOW(a_no_write_in_scan, mem_we, state != S_SCAN)
  // A granted result never leaves more space than the chosen entry had.
  `BFPA_ASSERT_NOW(a_write_back_fits, (state == S_DONE) && mem_we, best_val >= amount_q)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the best-fit partition allocator core.
`timescale 1ns / 1ps

// The testbench drives load and request transactions into the allocator and
// checks every result transaction against a table or a predictor of its own.
// The predictor keeps a copy of the free space of each partition and of the
// partition count. It updates that copy at the clock edge where a transaction
// is accepted. A request pushes its expected result into a queue, and the
// result monitor compares each accepted result with the oldest entry.
//
// The run starts with a short directed part. It is a table of transactions,
// and where the result is obvious the table holds it. Those cases are the
// empty partitions after reset, the largest size, refused requests, ties and
// zero-size requests. The other rows are checked against the predictor.
// After that the run walks through a list of partition counts. Among them
// are zero (every request is refused), one, eight and fifteen, which the
// block saturates to eight. Writes to the register index that does not
// exist are mixed in, and the block must ignore them. Each setting is
// followed by random transactions. Those are biased toward requests that fit
// a partition exactly, fit just barely or miss by one, and toward loads that
// create ties, so that the best-fit search is exercised in depth.
//
// Both sides idle at random. The sender leaves gaps between transactions,
// and the receiver raises result_stall for short and long stretches. Some
// stretches have no idling at all. A configuration write is only issued
// once every expected result has arrived and the block has had time to
// finish a trailing load.

module testbench;
  import bfpa_pkg::*;

  // A request holds the block only until its result is registered. The idle
  // wait is therefore ample to drain a load that produces no result.
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PRINT_LIMIT  = 100;

  // Register index that is not implemented. Writes to it must have no effect.
  localparam int REG_UNUSED = 1;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   part;
    logic [AMOUNT_W-1:0] left;
  } alloc_result_t;

  typedef struct packed {
    logic                kind;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
    logic                typed;
    alloc_result_t       want;
  } stim_row_t;

  localparam alloc_result_t REFUSED = '{1'b0, 3'd0, 16'd0};

  // These rows follow one another, so each one depends on the loads and
  // grants made by the rows above it.
  localparam int DIRECTED_ROWS = 21;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // After reset every partition is empty, so a request of one is refused.
    '{KIND_ALLOC, 3'd7, 16'd1,      1'b1, REFUSED},
    // A zero-size request fits an empty partition, and the lowest index wins.
    '{KIND_ALLOC, 3'd5, 16'd0,      1'b1, '{1'b1, 3'd0, 16'd0}},
    '{KIND_LOAD,  3'd7, 16'hFFFF,   1'b0, '0},
    '{KIND_ALLOC, 3'd0, 16'hFFFF,   1'b1, '{1'b1, 3'd7, 16'd0}},
    '{KIND_ALLOC, 3'd2, 16'hFFFF,   1'b1, REFUSED},
    '{KIND_LOAD,  3'd3, 16'd100,    1'b0, '0},
    '{KIND_LOAD,  3'd5, 16'd100,    1'b0, '0},
    '{KIND_LOAD,  3'd1, 16'd300,    1'b0, '0},
    // Partitions three and five tie, so three is chosen.
    '{KIND_ALLOC, 3'd6, 16'd50,     1'b1, '{1'b1, 3'd3, 16'd50}},
    '{KIND_ALLOC, 3'd1, 16'd60,     1'b1, '{1'b1, 3'd5, 16'd40}},
    '{KIND_ALLOC, 3'd4, 16'd45,     1'b1, '{1'b1, 3'd3, 16'd5}},
    '{KIND_ALLOC, 3'd3, 16'd0,      1'b1, '{1'b1, 3'd0, 16'd0}},
    '{KIND_ALLOC, 3'd0, 16'd301,    1'b1, REFUSED},
    '{KIND_LOAD,  3'd0, 16'hAAAA,   1'b0, '0},
    '{KIND_LOAD,  3'd2, 16'h5555,   1'b0, '0},
    '{KIND_ALLOC, 3'd7, 16'h5555,   1'b1, '{1'b1, 3'd2, 16'd0}},
    '{KIND_ALLOC, 3'd2, 16'h1234,   1'b1, '{1'b1, 3'd0, 16'h9876}},
    '{KIND_LOAD,  3'd4, 16'd40,     1'b0, '0},
    '{KIND_LOAD,  3'd6, 16'd40,     1'b0, '0},
    '{KIND_ALLOC, 3'd1, 16'd35,     1'b0, '0},
    '{KIND_ALLOC, 3'd6, 16'd41,     1'b0, '0}
  };

  // Partition counts for the random phases. The first entry is zero.
  localparam int PHASES = 15;
  localparam logic [CFG_W-1:0] PHASE_COUNTS [PHASES] = '{
    4'd0, 4'd1, 4'd15, 4'd8, 4'd2, 4'd7, 4'd9, 4'd3,
    4'd5, 4'd8, 4'd4, 4'd6, 4'd12, 4'd1, 4'd8
  };
  localparam int ZERO_PHASE_ITEMS = 25;
  localparam int PHASE_ITEMS      = 80;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic                kind = KIND_LOAD;
  logic [SLOT_W-1:0]   part_slot = '0;
  logic [AMOUNT_W-1:0] amount = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                granted;
  logic [SLOT_W-1:0]   chosen_part;
  logic [AMOUNT_W-1:0] space_left;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predictor state: the free space of each partition and the partition count.
  logic [AMOUNT_W-1:0] free_left [NUM_PARTS];
  logic [CFG_W-1:0]    search_count;

  alloc_result_t pending_grants [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            sender_calm = 1'b0;
  int            stall_left = 0;
  int            calm_left = 0;
  int            stall_roll;

  best_fit_partition_allocator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .part_slot    (part_slot),
    .amount       (amount),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .granted      (granted),
    .chosen_part  (chosen_part),
    .space_left   (space_left),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // The watchdog ends a run that hangs, for example when a result never comes.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count,
               what, got, want);
    mismatch_count++;
  endtask

  // Best-fit search over the searched partitions. It picks the smallest free
  // space that still covers the request, and the first index on a tie.
  // Counts above the partition total saturate.
  function automatic alloc_result_t best_fit_alloc(logic [AMOUNT_W-1:0] req);
    alloc_result_t res;
    int            limit;
    int            best;
    bit            found;
    res   = REFUSED;
    best  = 0;
    found = 1'b0;
    limit = (int'(search_count) > NUM_PARTS) ? NUM_PARTS : int'(search_count);
    for (int i = 0; i < limit; i++) begin
      if (free_left[i] >= req && (!found || free_left[i] < free_left[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      free_left[best] = free_left[best] - req;
      res.granted = 1'b1;
      res.part    = SLOT_W'(best);
      res.left    = free_left[best];
    end
    return res;
  endfunction

  // Short idle stretches are common. Longer ones are rare.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side. A transaction is taken at an edge where result_valid is high
  // and result_stall is low. It must match the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_grants.size() == 0) begin
        flag_mismatch("unexpected result", 32'({granted, chosen_part, space_left}), '0);
      end else begin
        if (granted !== pending_grants[0].granted)
          flag_mismatch("granted", 32'(granted), 32'(pending_grants[0].granted));
        if (chosen_part !== pending_grants[0].part)
          flag_mismatch("chosen_part", 32'(chosen_part), 32'(pending_grants[0].part));
        if (space_left !== pending_grants[0].left)
          flag_mismatch("space_left", 32'(space_left), 32'(pending_grants[0].left));
        void'(pending_grants.pop_front());
      end
    end
    // Back-pressure alternates between calm stretches and random stalls.
    if (calm_left > 0) begin
      calm_left--;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      stall_roll = $urandom_range(0, 999);
      if (stall_roll < 5)
        calm_left = $urandom_range(50, 300);
      else if (stall_roll < 250)
        stall_left = idle_length();
    end
  end

  // Sends one transaction and updates the predictor at the accepting edge.
  // The valid signal is lowered only when a gap follows, so it is never
  // lowered and raised within the same time step.
  task automatic send_item(input logic k, input logic [SLOT_W-1:0] s,
                           input logic [AMOUNT_W-1:0] a, input logic typed,
                           input alloc_result_t want);
    alloc_result_t res;
    int            gap;
    item_valid <= 1'b1;
    kind       <= k;
    part_slot  <= s;
    amount     <= a;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (k == KIND_LOAD) begin
      if (int'(s) < NUM_PARTS) free_left[s] = a;
    end else begin
      res = best_fit_alloc(a);
      pending_grants.push_back(typed ? want : res);
    end
    gap = (sender_calm || $urandom_range(0, 99) < 45) ? 0 : idle_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected result has arrived, then gives a trailing
  // load time to finish before the register is touched.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle that completes on pready.
  // The bus then idles before the task returns, so a following write starts on a later edge.
  task automatic write_register(input int index, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * index);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == int'(REG_PARTS_IN_USE)) search_count = data[CFG_W-1:0];
    @(posedge clk);
  endtask

  // Random transaction, shaped by the predictor's view of the partitions.
  // Requests often fit a partition exactly, just barely, or miss it by one.
  // Loads often copy another partition's size to create ties.
  task automatic random_item(output logic k, output logic [SLOT_W-1:0] s,
                             output logic [AMOUNT_W-1:0] a);
    int roll;
    int limit;
    int pick;
    int room;
    roll = $urandom_range(0, 99);
    s    = SLOT_W'($urandom_range(0, NUM_PARTS - 1));
    if (roll < 30) begin
      k    = KIND_LOAD;
      roll = $urandom_range(0, 99);
      if (roll < 25)      a = free_left[$urandom_range(0, NUM_PARTS - 1)];
      else if (roll < 60) a = AMOUNT_W'($urandom_range(0, 300));
      else if (roll < 85) a = AMOUNT_W'($urandom());
      else if (roll < 95) a = ($urandom_range(0, 1) == 0) ? '0 : '1;
      else                a = AMOUNT_W'($urandom_range(16'hFFF0, 16'hFFFF));
    end else begin
      k     = KIND_ALLOC;
      limit = (int'(search_count) > NUM_PARTS) ? NUM_PARTS : int'(search_count);
      pick  = (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, NUM_PARTS - 1);
      room  = int'(free_left[pick]);
      roll  = $urandom_range(0, 99);
      if (roll < 30)      a = AMOUNT_W'(room);
      else if (roll < 55) a = AMOUNT_W'(room - $urandom_range(0, (room < 20) ? room : 20));
      else if (roll < 65) a = AMOUNT_W'(room + 1);
      else if (roll < 80) a = AMOUNT_W'($urandom_range(0, 50));
      else if (roll < 95) a = AMOUNT_W'($urandom());
      else                a = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end
  endtask

  initial begin
    logic                k;
    logic [SLOT_W-1:0]   s;
    logic [AMOUNT_W-1:0] a;
    int                  items;

    foreach (free_left[i]) free_left[i] = '0;
    search_count = PARTS_IN_USE_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run with the partition count left at its reset value.
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_item(DIRECTED[r].kind, DIRECTED[r].slot, DIRECTED[r].amount,
                DIRECTED[r].typed, DIRECTED[r].want);

    // Random phases, one for each partition count. The upper data bits are
    // random or zero and must be dropped. Each phase also writes the unused register
    // index with even odds, and that write must change nothing.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if ($urandom_range(0, 1) == 1)
        write_register(REG_UNUSED, $urandom());
      write_register(int'(REG_PARTS_IN_USE),
                     (((($urandom_range(0, 1) == 1) ? DATA_W'($urandom()) : DATA_W'(0))
                       >> CFG_W) << CFG_W) | DATA_W'(PHASE_COUNTS[p]));
      sender_calm = ($urandom_range(0, 99) < 20);
      items = (PHASE_COUNTS[p] == 0) ? ZERO_PHASE_ITEMS : PHASE_ITEMS;
      for (int n = 0; n < items; n++) begin
        random_item(k, s, a);
        send_item(k, s, a, 1'b0, REFUSED);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bfpa_pkg.sv
src/best_fit_partition_allocator_core.sv
tb/sv/testbench.sv
